// ----- rtl/fbfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfs_pkg: shared types and constants of the free block fit search
// Holds the fit policy codes, the register and mode codes, the field widths
// and the small structs that pass between the search cells.
// ----------------------------------------------------------------------------
package fbfs_pkg;

	localparam int SLOT_W       = 4;
	localparam int BLOCK_SIZE_W = 32;
	localparam int ID_W         = 16;
	localparam int LEN_W        = 5;
	localparam int POLICY_W     = 2;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_INDEX_W  = 1;
	localparam int IN_TDATA_W   = 88;
	localparam int OUT_TDATA_W  = 16;

	typedef enum logic [POLICY_W-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NONE  = 2'd3
	} fit_policy_t;

	localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_LIST_LENGTH = 1'b1;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		fit_policy_t            policy;
		logic [LEN_W-1:0]       list_length;
	} fbfs_cfg_t;

	typedef struct packed {
		logic vld;
		logic have;
	} cand_ctl_t;

endpackage

// ----- rtl/fbfs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfs_cell: one table entry and one step of the fit search
// Stores the size and id of one free block and updates the candidate that
// passes through it, handing the result on to the next cell each cycle that the row advances.
// ----------------------------------------------------------------------------
module fbfs_cell import fbfs_pkg::*; #(
	parameter int SIZE_BITS  = 32,
	parameter int CELL_INDEX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  fbfs_cfg_t            cfg,
	input  logic                 wr_en,
	input  logic [SIZE_BITS-1:0] wr_size,
	input  logic [ID_W-1:0]      wr_id,
	input  cand_ctl_t            in_ctl,
	input  logic [SIZE_BITS-1:0] in_keep,
	input  logic [ID_W-1:0]      in_pick,
	input  logic [SIZE_BITS-1:0] in_req,
	output cand_ctl_t            out_ctl,
	output logic [SIZE_BITS-1:0] out_keep,
	output logic [ID_W-1:0]      out_pick,
	output logic [SIZE_BITS-1:0] out_req
);

	logic [SIZE_BITS-1:0] size_q;
	logic [ID_W-1:0]      id_q;
	cand_ctl_t            ctl_q;
	logic [SIZE_BITS-1:0] keep_q;
	logic [ID_W-1:0]      pick_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 in_list;
	logic                 fits;
	logic                 take;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			size_q <= wr_size;
			id_q   <= wr_id;
		end
	end

	assign in_list = 32'(cfg.list_length) > 32'(CELL_INDEX);
	assign fits    = size_q >= in_req;

	always_comb begin
		take = 1'b0;
		if (in_list) begin
			unique case (cfg.policy)
				FIT_FIRST: take = fits && !in_ctl.have;
				FIT_BEST:  take = fits && (!in_ctl.have || size_q < in_keep);
				FIT_WORST: take = fits && size_q > in_keep;
				FIT_NONE:  take = 1'b0;
				default:   take = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q.vld  <= in_ctl.vld;
			ctl_q.have <= in_ctl.have || take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keep_q <= take ? size_q : in_keep;
			pick_q <= take ? id_q : in_pick;
			req_q  <= in_req;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_keep = keep_q;
	assign out_pick = pick_q;
	assign out_req  = req_q;

endmodule

// ----- rtl/free_block_fit_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_fit_search: first, best and worst fit search over a block table
// A row of cells holds the table of free blocks; a query walks the row and
// returns the id of the block chosen by the configured policy.
// ----------------------------------------------------------------------------
// Usage: input transactions arrive on s_tvalid/s_tready. With s_tuser low a
// transaction writes one table slot and gives no result; with s_tuser high it
// is a query that gives exactly one result on m_tvalid/m_tready, with the
// found flag on m_tuser and the chosen id on m_tdata.
// The configuration channel writes the fit policy (index 0) and the list
// length (index 1); it is always ready. The user must write it only while
// idle; the block does not enforce this. A query passes through all
// TABLE_DEPTH cells, one cell per cycle while the row advances, and its
// result is loaded into the output register as it leaves the last cell;
// no new transaction is taken until that load. Every query walks the
// whole cell row, whatever the list length.
// The result waits in an output register while the receiver stalls; the next
// query may run meanwhile and then holds in the last cell until the output
// register frees. Reset clears the policy, the list length and all control
// state; table entries hold nothing defined until written.
// ----------------------------------------------------------------------------
module free_block_fit_search import fbfs_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int SIZE_BITS   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// slot [3:0], block_size [35:4], block_id [51:36], request_size [83:52]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode [0]
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// chosen_id [15:0]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// found [0]
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [SLOT_W-1:0]       in_slot;
	logic [BLOCK_SIZE_W-1:0] in_block_size;
	logic [ID_W-1:0]         in_block_id;
	logic [BLOCK_SIZE_W-1:0] in_request_size;

	fbfs_cfg_t            cfg_q;
	logic                 busy_q;
	logic                 m_tvalid_q;
	logic                 found_q;
	logic [ID_W-1:0]      chosen_id_q;

	logic                 in_acc;
	logic                 wr_acc;
	logic                 qry_acc;
	logic                 adv;
	logic                 load;
	logic [SIZE_BITS-1:0] wr_size;

	cand_ctl_t            ctl_c  [TABLE_DEPTH+1];
	logic [SIZE_BITS-1:0] keep_c [TABLE_DEPTH+1];
	logic [ID_W-1:0]      pick_c [TABLE_DEPTH+1];
	logic [SIZE_BITS-1:0] req_c  [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] vld_vec;

	assign in_slot         = s_tdata[3:0];
	assign in_block_size   = s_tdata[35:4];
	assign in_block_id     = s_tdata[51:36];
	assign in_request_size = s_tdata[83:52];

	assign s_tready  = !busy_q;
	assign in_acc    = s_tvalid && s_tready;
	assign wr_acc    = in_acc && (s_tuser == MODE_WRITE);
	assign qry_acc   = in_acc && (s_tuser == MODE_QUERY);
	assign wr_size   = SIZE_BITS'(in_block_size);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy      <= FIT_FIRST;
			cfg_q.list_length <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIT_POLICY:  cfg_q.policy      <= fit_policy_t'(cfg_data[POLICY_W-1:0]);
				REG_LIST_LENGTH: cfg_q.list_length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign ctl_c[0].vld  = qry_acc;
	assign ctl_c[0].have = 1'b0;
	assign keep_c[0]     = '0;
	assign pick_c[0]     = '0;
	assign req_c[0]      = SIZE_BITS'(in_request_size);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		fbfs_cell #(
			.SIZE_BITS  (SIZE_BITS),
			.CELL_INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cfg      (cfg_q),
			.wr_en    (wr_acc && (32'(in_slot) == 32'(i))),
			.wr_size  (wr_size),
			.wr_id    (in_block_id),
			.in_ctl   (ctl_c[i]),
			.in_keep  (keep_c[i]),
			.in_pick  (pick_c[i]),
			.in_req   (req_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_keep (keep_c[i+1]),
			.out_pick (pick_c[i+1]),
			.out_req  (req_c[i+1])
		);
		assign vld_vec[i] = ctl_c[i+1].vld;
	end

	assign load = ctl_c[TABLE_DEPTH].vld && (!m_tvalid_q || m_tready);
	assign adv  = !ctl_c[TABLE_DEPTH].vld || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (qry_acc) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q     <= ctl_c[TABLE_DEPTH].have;
			chosen_id_q <= pick_c[TABLE_DEPTH];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = chosen_id_q;

`ifndef SYNTHESIS
	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) <= 1)
		else $error("more than one query in the cell row");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_vec != '0) |-> busy_q)
		else $error("query in the cell row while not busy");

	a_row_empty_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		qry_acc |-> (vld_vec == '0))
		else $error("query accepted while the cell row is occupied");

	a_result_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(ctl_c[TABLE_DEPTH].vld))
		else $error("result raised without a query leaving the cell row");
`endif

endmodule

// ----- tb/tb_free_block_fit_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_block_fit_search: self-checking bench for the free block fit search
// Loads the block table, then runs queries under first, best and worst fit
// and the unused policy code, over many list lengths. A predictor computes
// the chosen id of every accepted query, and a monitor compares each result
// transaction with the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_free_block_fit_search;
	import fbfs_pkg::*;

	localparam int TABLE_DEPTH   = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PAD_W         = IN_TDATA_W - (SLOT_W + 2 * BLOCK_SIZE_W + ID_W);

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_CONFIG,
		OP_DRAIN
	} op_kind_t;

	typedef struct {
		op_kind_t                kind;
		logic                    mode;
		logic [SLOT_W-1:0]       slot;
		logic [BLOCK_SIZE_W-1:0] block_size;
		logic [ID_W-1:0]         block_id;
		logic [BLOCK_SIZE_W-1:0] request_size;
		logic [CFG_INDEX_W-1:0]  cfg_index;
		logic [CFG_DATA_W-1:0]   cfg_data;
	} bus_op_t;

	typedef struct {
		logic            found;
		logic [ID_W-1:0] chosen_id;
	} fit_answer_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	bus_op_t     bus_ops[$];
	fit_answer_t fit_answers[$];

	logic [BLOCK_SIZE_W-1:0] tbl_size [TABLE_DEPTH];
	logic [ID_W-1:0]         tbl_id   [TABLE_DEPTH];
	logic [BLOCK_SIZE_W-1:0] gen_size [TABLE_DEPTH];
	fit_policy_t             cur_policy = FIT_FIRST;
	logic [LEN_W-1:0]        cur_len    = '0;

	int tx_wait    = 0;
	int tx_calm    = 0;
	int rx_wait    = 0;
	int rx_calm    = 0;
	int settle     = 0;
	int fail_count = 0;

	free_block_fit_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SIZE_BITS  (BLOCK_SIZE_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_wait(inout int calm);
		int w;
		if (calm > 0) begin
			calm = calm - 1;
			w = 0;
		end else begin
			if ($urandom_range(0, 39) == 0)
				calm = $urandom_range(20, 60);
			w = $urandom_range(0, 11);
		end
		return w;
	endfunction

	function automatic fit_answer_t fit_search(logic [BLOCK_SIZE_W-1:0] req);
		fit_answer_t             ans;
		logic [BLOCK_SIZE_W-1:0] keep;
		logic [BLOCK_SIZE_W-1:0] left;
		int                      n;
		ans.found = 1'b0;
		ans.chosen_id = '0;
		keep = '0;
		n = (cur_len > TABLE_DEPTH) ? TABLE_DEPTH : cur_len;
		for (int i = 0; i < n; i++) begin
			if (tbl_size[i] >= req) begin
				case (cur_policy)
					FIT_FIRST: begin
						if (!ans.found) begin
							ans.found = 1'b1;
							ans.chosen_id = tbl_id[i];
						end
					end
					FIT_BEST: begin
						left = tbl_size[i] - req;
						if (!ans.found || left < keep) begin
							ans.found = 1'b1;
							keep = left;
							ans.chosen_id = tbl_id[i];
						end
					end
					FIT_WORST: begin
						if (tbl_size[i] > keep) begin
							ans.found = 1'b1;
							keep = tbl_size[i];
							ans.chosen_id = tbl_id[i];
						end
					end
					default: ;
				endcase
			end
		end
		return ans;
	endfunction

	function automatic logic [BLOCK_SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	function automatic logic [BLOCK_SIZE_W-1:0] rand_request();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return gen_size[$urandom_range(0, TABLE_DEPTH - 1)];
			4: return gen_size[$urandom_range(0, TABLE_DEPTH - 1)] + 1'b1;
			5: return $urandom;
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	task automatic push_write(logic [SLOT_W-1:0] slot, logic [BLOCK_SIZE_W-1:0] size,
			logic [ID_W-1:0] id);
		bus_op_t op;
		op.kind = OP_ITEM;
		op.mode = MODE_WRITE;
		op.slot = slot;
		op.block_size = size;
		op.block_id = id;
		op.request_size = $urandom;
		op.cfg_index = '0;
		op.cfg_data = '0;
		gen_size[slot] = size;
		bus_ops.push_back(op);
	endtask

	task automatic push_query(logic [BLOCK_SIZE_W-1:0] req);
		bus_op_t op;
		op.kind = OP_ITEM;
		op.mode = MODE_QUERY;
		op.slot = SLOT_W'($urandom);
		op.block_size = $urandom;
		op.block_id = ID_W'($urandom);
		op.request_size = req;
		op.cfg_index = '0;
		op.cfg_data = '0;
		bus_ops.push_back(op);
	endtask

	task automatic push_control(op_kind_t kind, logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		bus_op_t op;
		op.kind = kind;
		op.mode = MODE_WRITE;
		op.slot = '0;
		op.block_size = '0;
		op.block_id = '0;
		op.request_size = '0;
		op.cfg_index = idx;
		op.cfg_data = data;
		bus_ops.push_back(op);
	endtask

	task automatic push_setting(logic [POLICY_W-1:0] pol, logic [LEN_W-1:0] len,
			logic [CFG_DATA_W-POLICY_W-1:0] upper);
		if ($urandom_range(0, 1)) begin
			push_control(OP_CONFIG, REG_FIT_POLICY, {upper, pol});
			push_control(OP_CONFIG, REG_LIST_LENGTH, len);
		end else begin
			push_control(OP_CONFIG, REG_LIST_LENGTH, len);
			push_control(OP_CONFIG, REG_FIT_POLICY, {upper, pol});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		bus_op_t op;
		logic    fin;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			tx_wait <= 0;
			settle <= 0;
		end else begin
			fin = 1'b0;
			if (s_tvalid && s_tready) begin
				op = bus_ops.pop_front();
				if (op.mode == MODE_WRITE) begin
					tbl_size[op.slot] = op.block_size;
					tbl_id[op.slot] = op.block_id;
				end else begin
					fit_answers.push_back(fit_search(op.request_size));
				end
				fin = 1'b1;
			end else if (cfg_valid && cfg_ready) begin
				op = bus_ops.pop_front();
				if (op.cfg_index == REG_FIT_POLICY)
					cur_policy = fit_policy_t'(op.cfg_data[POLICY_W-1:0]);
				else
					cur_len = op.cfg_data;
				fin = 1'b1;
			end
			if (fin || !(s_tvalid || cfg_valid)) begin
				if (bus_ops.size() == 0) begin
					s_tvalid <= 1'b0;
					cfg_valid <= 1'b0;
				end else begin
					op = bus_ops[0];
					if (op.kind == OP_ITEM) begin
						cfg_valid <= 1'b0;
						if (tx_wait > 0) begin
							tx_wait <= tx_wait - 1;
							s_tvalid <= 1'b0;
						end else begin
							s_tvalid <= 1'b1;
							s_tuser <= op.mode;
							s_tdata <= {{PAD_W{1'b0}}, op.request_size, op.block_id,
								op.block_size, op.slot};
							tx_wait <= draw_wait(tx_calm);
						end
					end else begin
						s_tvalid <= 1'b0;
						if (fit_answers.size() != 0) begin
							settle <= 0;
							cfg_valid <= 1'b0;
						end else if (settle < SETTLE_CYCLES) begin
							settle <= settle + 1;
							cfg_valid <= 1'b0;
						end else begin
							settle <= 0;
							if (op.kind == OP_DRAIN) begin
								bus_ops.delete(0);
								cfg_valid <= 1'b0;
							end else begin
								cfg_valid <= 1'b1;
								cfg_index <= op.cfg_index;
								cfg_data <= op.cfg_data;
							end
						end
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		fit_answer_t want;
		int          n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			if (fit_answers.size() == 0) begin
				$error("result with no query outstanding: found %0d chosen_id %0h",
					m_tuser, m_tdata);
				fail_count++;
			end else begin
				want = fit_answers.pop_front();
				if (m_tuser !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, m_tuser);
					fail_count++;
				end
				if (m_tdata !== want.chosen_id) begin
					$error("chosen_id: expected %0h, actual %0h", want.chosen_id, m_tdata);
					fail_count++;
				end
			end
			n = draw_wait(rx_calm);
			m_tready <= (n == 0);
			rx_wait <= n;
		end else if (!m_tready && (m_tvalid || rx_wait == 0)) begin
			if (rx_wait == 0)
				m_tready <= 1'b1;
			else
				rx_wait <= rx_wait - 1;
		end
	end

	initial begin : run
		int guard;
		int items;
		int half;
		logic [POLICY_W-1:0] pol;
		logic [LEN_W-1:0]    len;

		// Empty list straight after reset: no block can be chosen.
		push_query('0);
		push_write(4'd0, 32'd100, 16'h0001);
		push_write(4'd1, 32'd0, 16'hFFFF);
		push_write(4'd2, 32'hFFFF_FFFF, 16'h1234);
		push_write(4'd3, 32'd50, 16'h0000);
		push_write(4'd4, 32'd200, 16'h00C8);
		push_write(4'd5, 32'd100, 16'h0500);
		push_write(4'd6, 32'hFFFF_FFFF, 16'h0600);
		for (int i = 7; i < TABLE_DEPTH; i++)
			push_write(SLOT_W'(i), BLOCK_SIZE_W'(10 + 7 * i), ID_W'($urandom));
		// Lengths above the table depth saturate.
		push_setting(FIT_FIRST, 5'd31, 3'b000);
		push_query(32'd101);
		push_query('1);
		push_setting(FIT_BEST, 5'd16, 3'b000);
		push_query(32'd100);
		push_query('0);
		push_setting(FIT_WORST, 5'd17, 3'b000);
		push_query('0);
		push_setting(FIT_WORST, 5'd2, 3'b000);
		push_query(32'd101);
		push_query('0);
		push_setting(FIT_NONE, 5'd16, 3'b111);
		push_query('0);

		for (int p = 0; p < 14; p++) begin
			case (p)
				0: begin pol = FIT_FIRST; len = 5'd16; end
				1: begin pol = FIT_BEST;  len = 5'd16; end
				2: begin pol = FIT_WORST; len = 5'd16; end
				3: begin pol = FIT_BEST;  len = 5'd1;  end
				4: begin pol = FIT_FIRST; len = 5'd0;  end
				default: begin
					pol = ($urandom_range(0, 9) == 0) ? FIT_NONE
						: POLICY_W'($urandom_range(0, 2));
					case ($urandom_range(0, 5))
						0: len = 5'd16;
						1: len = LEN_W'($urandom_range(17, 31));
						2: len = 5'd1;
						default: len = LEN_W'($urandom_range(0, 16));
					endcase
				end
			endcase
			push_setting(pol, len, (CFG_DATA_W - POLICY_W)'($urandom));
			items = $urandom_range(90, 118);
			half = items / 2;
			for (int k = 0; k < items; k++) begin
				if (k == half)
					push_control(OP_DRAIN, '0, '0);
				if ($urandom_range(0, 99) < 55)
					push_query(rand_request());
				else
					push_write(SLOT_W'($urandom), rand_size(), ID_W'($urandom));
			end
		end

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bus_ops.size() != 0 || s_tvalid || cfg_valid)
			@(posedge clk);
		guard = 0;
		while (fit_answers.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fit_answers.size() != 0) begin
			$error("%0d predicted results never arrived", fit_answers.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_free_block_fit_search: done, clean");
		else
			$display("tb_free_block_fit_search: done, errors");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb_free_block_fit_search: done, errors");
		$finish;
	end

endmodule
